[design/mi3_pkg.sv]
`default_nettype none

package mi3_pkg;

    // Adjugate element k = e[p]*e[q] - e[r]*e[s]
    localparam logic [3:0] ADJ_IDX [9][4] = '{
        '{4'd4, 4'd8, 4'd7, 4'd5}, '{4'd7, 4'd2, 4'd1, 4'd8}, '{4'd1, 4'd5, 4'd4, 4'd2},
        '{4'd6, 4'd5, 4'd3, 4'd8}, '{4'd0, 4'd8, 4'd6, 4'd2}, '{4'd3, 4'd2, 4'd0, 4'd5},
        '{4'd3, 4'd7, 4'd6, 4'd4}, '{4'd6, 4'd1, 4'd0, 4'd7}, '{4'd0, 4'd4, 4'd3, 4'd1}
    };

    // Elements of column 0, paired with adjugate elements 0..2 for the determinant
    localparam logic [3:0] COL_IDX [3] = '{4'd0, 4'd3, 4'd6};

    typedef struct packed {
        logic neg;
        logic zero;
    } det_flag_t;

    typedef struct packed {
        logic det_zero;
        logic div_ovf;
        logic adj_ovf;
    } lane_flag_t;

    typedef struct packed {
        logic singular;
        logic overflow;
    } res_flag_t;

endpackage

`default_nettype wire

[design/mi3_front.sv]
`default_nettype none

module mi3_front #(
    parameter int W = 32
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic signed [W-1:0]      e [9],
    output logic signed [2*W:0]      adj_out [9],
    output logic [3*W+3:0]           dmag_out,
    output mi3_pkg::det_flag_t       dflag_out
);
    import mi3_pkg::*;

    localparam int PW   = 2 * W;
    localparam int AW   = 2 * W + 1;
    localparam int TW   = 3 * W + 2;
    localparam int DETW = 3 * W + 4;

    logic signed [PW-1:0]   prod_p_reg [9];
    logic signed [PW-1:0]   prod_t_reg [9];
    logic signed [W-1:0]    col0_reg [3];
    logic signed [W-1:0]    col1_reg [3];
    logic signed [AW-1:0]   adj1_reg [9];
    logic signed [AW-1:0]   adj2_reg [9];
    logic signed [AW-1:0]   adj3_reg [9];
    logic signed [AW-1:0]   adj4_reg [9];
    logic signed [AW-1:0]   adj5_reg [9];
    logic signed [AW:0]     part_lo_reg [3];
    logic signed [AW:0]     part_hi_reg [3];
    logic signed [TW-1:0]   term_reg [3];
    logic signed [DETW-1:0] det_reg;
    logic [DETW-1:0]        dmag_reg;
    det_flag_t              dflag_reg;

    genvar k;
    generate
        for (k = 0; k < 9; k++) begin : g_cof
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    prod_p_reg[k] <= PW'(e[ADJ_IDX[k][0]]) * PW'(e[ADJ_IDX[k][1]]);
                    prod_t_reg[k] <= PW'(e[ADJ_IDX[k][2]]) * PW'(e[ADJ_IDX[k][3]]);
                    adj1_reg[k]   <= AW'(prod_p_reg[k]) - AW'(prod_t_reg[k]);
                    adj2_reg[k]   <= adj1_reg[k];
                    adj3_reg[k]   <= adj2_reg[k];
                    adj4_reg[k]   <= adj3_reg[k];
                    adj5_reg[k]   <= adj4_reg[k];
                end
            end
            assign adj_out[k] = adj5_reg[k];
        end

        for (k = 0; k < 3; k++) begin : g_det
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    col0_reg[k]    <= e[COL_IDX[k]];
                    col1_reg[k]    <= col0_reg[k];
                    part_lo_reg[k] <= (AW + 1)'(col1_reg[k])
                                      * (AW + 1)'($signed({1'b0, adj1_reg[k][W-1:0]}));
                    part_hi_reg[k] <= (AW + 1)'(col1_reg[k])
                                      * (AW + 1)'($signed(adj1_reg[k][2*W:W]));
                    term_reg[k]    <= (TW'(part_hi_reg[k]) <<< W) + TW'(part_lo_reg[k]);
                end
            end
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            det_reg        <= DETW'(term_reg[0]) + DETW'(term_reg[1]) + DETW'(term_reg[2]);
            dflag_reg.neg  <= det_reg[DETW-1];
            dflag_reg.zero <= (det_reg == '0);
            dmag_reg       <= det_reg[DETW-1] ? DETW'(-det_reg) : DETW'(det_reg);
        end
    end

    assign dmag_out  = dmag_reg;
    assign dflag_out = dflag_reg;

endmodule

`default_nettype wire

[design/mi3_lane.sv]
`default_nettype none

module mi3_lane #(
    parameter int W = 32,
    parameter int F = 16
) (
    input  logic                   clk,
    input  logic                   en,
    input  logic signed [2*W:0]    adj,
    input  logic [3*W+3:0]         dmag,
    input  mi3_pkg::det_flag_t     dflag,
    output logic signed [W-1:0]    div_elem,
    output logic signed [W-1:0]    adj_elem,
    output mi3_pkg::lane_flag_t    flags
);
    import mi3_pkg::*;

    localparam int AW   = 2 * W + 1;
    localparam int DETW = 3 * W + 4;
    localparam int NW   = AW + 2 * F;
    localparam int SW   = DETW + W;
    localparam int RW   = ((NW > SW) ? NW : SW) + 1;
    localparam logic [W-1:0] HALF = {1'b1, {(W-1){1'b0}}};
    localparam logic [W-1:0] MAXP = {1'b0, {(W-1){1'b1}}};

    logic                 nneg;
    logic [AW-1:0]        nmag;
    logic signed [AW-1:0] ash;
    logic                 ash_fit;
    logic [W-1:0]         ash_sat;

    logic [RW-1:0]        num_a_reg;
    logic [DETW-1:0]      dmag_a_reg;
    logic                 neg_a_reg;
    logic                 zero_a_reg;
    logic [W-1:0]         aval_a_reg;
    logic                 aovf_a_reg;

    logic [RW-1:0]        rem_reg  [W+1];
    logic [W-1:0]         quo_reg  [W+1];
    logic [DETW-1:0]      dmag_reg [W+1];
    logic                 big_reg  [W+1];
    logic                 neg_reg  [W+1];
    logic                 zero_reg [W+1];
    logic [W-1:0]         aval_reg [W+1];
    logic                 aovf_reg [W+1];

    logic [W-1:0]         q;
    logic [W-1:0]         dval;
    logic                 dovf;

    logic [W-1:0]         div_elem_reg;
    logic [W-1:0]         adj_elem_reg;
    lane_flag_t           flags_reg;

    assign nneg    = adj[AW-1];
    assign nmag    = nneg ? AW'(-adj) : AW'(adj);
    assign ash     = adj >>> F;
    assign ash_fit = (&ash[AW-1:W-1]) || !(|ash[AW-1:W-1]);
    assign ash_sat = ash_fit ? ash[W-1:0] : (ash[AW-1] ? HALF : MAXP);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num_a_reg  <= RW'(nmag) << (2 * F);
            dmag_a_reg <= dmag;
            neg_a_reg  <= nneg ^ dflag.neg;
            zero_a_reg <= dflag.zero;
            aval_a_reg <= ash_sat;
            aovf_a_reg <= !ash_fit;

            rem_reg[0]  <= num_a_reg;
            quo_reg[0]  <= '0;
            dmag_reg[0] <= dmag_a_reg;
            big_reg[0]  <= (num_a_reg >= (RW'(dmag_a_reg) << W));
            neg_reg[0]  <= neg_a_reg;
            zero_reg[0] <= zero_a_reg;
            aval_reg[0] <= aval_a_reg;
            aovf_reg[0] <= aovf_a_reg;
        end
    end

    genvar s;
    generate
        for (s = 1; s <= W; s++) begin : g_div
            logic [RW-1:0] dsh;
            logic          ge;

            assign dsh = RW'(dmag_reg[s-1]) << (W - s);
            assign ge  = (rem_reg[s-1] >= dsh);

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[s]  <= ge ? (rem_reg[s-1] - dsh) : rem_reg[s-1];
                    quo_reg[s]  <= quo_reg[s-1] | (W'(ge) << (W - s));
                    dmag_reg[s] <= dmag_reg[s-1];
                    big_reg[s]  <= big_reg[s-1];
                    neg_reg[s]  <= neg_reg[s-1];
                    zero_reg[s] <= zero_reg[s-1];
                    aval_reg[s] <= aval_reg[s-1];
                    aovf_reg[s] <= aovf_reg[s-1];
                end
            end
        end
    endgenerate

    assign q = quo_reg[W];

    always_comb
    begin
        dval = q;
        dovf = 1'b0;
        if (big_reg[W])
        begin
            dovf = 1'b1;
            dval = neg_reg[W] ? HALF : MAXP;
        end
        else if (neg_reg[W])
        begin
            if (q > HALF)
            begin
                dovf = 1'b1;
                dval = HALF;
            end
            else
            begin
                dval = W'(-q);
            end
        end
        else if (q >= HALF)
        begin
            dovf = 1'b1;
            dval = MAXP;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            div_elem_reg       <= dval;
            adj_elem_reg       <= aval_reg[W];
            flags_reg.det_zero <= zero_reg[W];
            flags_reg.div_ovf  <= dovf;
            flags_reg.adj_ovf  <= aovf_reg[W];
        end
    end

    assign div_elem = $signed(div_elem_reg);
    assign adj_elem = $signed(adj_elem_reg);
    assign flags    = flags_reg;

endmodule

`default_nettype wire

[design/mi3_merge.sv]
`default_nettype none

module mi3_merge #(
    parameter int W = 32
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  logic                   mode,
    input  logic signed [W-1:0]    div_elem [9],
    input  logic signed [W-1:0]    adj_elem [9],
    input  mi3_pkg::lane_flag_t    flags [9],
    output logic                   space,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic signed [W-1:0]    out_elem [9],
    output mi3_pkg::res_flag_t     out_flag
);
    import mi3_pkg::*;

    logic signed [W-1:0] res_elem [9];
    res_flag_t           res_flag;
    logic                any_ovf;
    logic                pop;

    logic signed [W-1:0] elem_mem [2][9];
    res_flag_t           flag_mem [2];
    logic                wr_ptr_reg;
    logic                wr_ptr_next;
    logic                rd_ptr_reg;
    logic                rd_ptr_next;
    logic [1:0]          count_reg;
    logic [1:0]          count_next;

    always_comb
    begin
        any_ovf = 1'b0;
        for (int k = 0; k < 9; k++)
        begin
            any_ovf = any_ovf | (mode ? flags[k].div_ovf : flags[k].adj_ovf);
        end
        res_flag.singular = mode && flags[0].det_zero;
        res_flag.overflow = !res_flag.singular && any_ovf;
        for (int k = 0; k < 9; k++)
        begin
            if (res_flag.singular)
            begin
                res_elem[k] = '0;
            end
            else
            begin
                res_elem[k] = mode ? div_elem[k] : adj_elem[k];
            end
        end
    end

    assign pop = out_valid && out_ready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            elem_mem[wr_ptr_reg] <= res_elem;
            flag_mem[wr_ptr_reg] <= res_flag;
        end
    end

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        case ({push, pop})
            2'b10:   count_next = count_reg + 2'd1;
            2'b01:   count_next = count_reg - 2'd1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assign space     = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_elem  = elem_mem[rd_ptr_reg];
    assign out_flag  = flag_mem[rd_ptr_reg];

endmodule

`default_nettype wire

[design/matrix_inverse_3x3_core.sv]
`default_nettype none

// Channel   Direction  Handshake              Payload
// in        input      in_valid / in_ready    in_e0..in_e8 (signed, DATA_WIDTH)
// out       output     out_valid / out_ready  out_e0..out_e8, singular, overflow
// cfg       input      cfg_valid / cfg_ready  divide_by_determinant
//
// One matrix per cycle while the result buffer has space; pipeline of six cofactor/determinant
// stages, DATA_WIDTH + 3 divider stages per lane, then the result buffer.
// The divider lanes retire one quotient bit per stage.
// Reset clears the pipeline valid bits and the buffer; mode resets to inverse.
// A two-entry result buffer keeps the pipeline moving while a result waits;
// the pipeline holds only when both entries are occupied.

module matrix_inverse_3x3_core #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic signed [DATA_WIDTH-1:0] in_e0,
    input  logic signed [DATA_WIDTH-1:0] in_e1,
    input  logic signed [DATA_WIDTH-1:0] in_e2,
    input  logic signed [DATA_WIDTH-1:0] in_e3,
    input  logic signed [DATA_WIDTH-1:0] in_e4,
    input  logic signed [DATA_WIDTH-1:0] in_e5,
    input  logic signed [DATA_WIDTH-1:0] in_e6,
    input  logic signed [DATA_WIDTH-1:0] in_e7,
    input  logic signed [DATA_WIDTH-1:0] in_e8,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic signed [DATA_WIDTH-1:0] out_e0,
    output logic signed [DATA_WIDTH-1:0] out_e1,
    output logic signed [DATA_WIDTH-1:0] out_e2,
    output logic signed [DATA_WIDTH-1:0] out_e3,
    output logic signed [DATA_WIDTH-1:0] out_e4,
    output logic signed [DATA_WIDTH-1:0] out_e5,
    output logic signed [DATA_WIDTH-1:0] out_e6,
    output logic signed [DATA_WIDTH-1:0] out_e7,
    output logic signed [DATA_WIDTH-1:0] out_e8,
    output logic                         singular,
    output logic                         overflow,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic                         divide_by_determinant
);
    import mi3_pkg::*;

    localparam int W    = DATA_WIDTH;
    localparam int NSTG = W + 9;

    logic signed [W-1:0]   e [9];
    logic signed [2*W:0]   adj [9];
    logic [3*W+3:0]        dmag;
    det_flag_t             dflag;
    logic signed [W-1:0]   div_elem [9];
    logic signed [W-1:0]   adj_elem [9];
    lane_flag_t            flags [9];
    logic signed [W-1:0]   out_elem [9];
    res_flag_t             out_flag;

    logic                  en;
    logic                  push;
    logic [NSTG-1:0]       valid_reg;
    logic                  mode_reg;

    assign e[0] = in_e0;
    assign e[1] = in_e1;
    assign e[2] = in_e2;
    assign e[3] = in_e3;
    assign e[4] = in_e4;
    assign e[5] = in_e5;
    assign e[6] = in_e6;
    assign e[7] = in_e7;
    assign e[8] = in_e8;

    assign in_ready  = en;
    assign cfg_ready = 1'b1;
    assign push      = en && valid_reg[NSTG-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            mode_reg  <= 1'b1;
        end
        else
        begin
            if (en)
            begin
                valid_reg <= {valid_reg[NSTG-2:0], in_valid};
            end
            if (cfg_valid)
            begin
                mode_reg <= divide_by_determinant;
            end
        end
    end

    mi3_front #(
        .W (W)
    ) u_front (
        .clk       (clk),
        .en        (en),
        .e         (e),
        .adj_out   (adj),
        .dmag_out  (dmag),
        .dflag_out (dflag)
    );

    genvar k;
    generate
        for (k = 0; k < 9; k++) begin : g_lane
            mi3_lane #(
                .W (W),
                .F (FRAC_BITS)
            ) u_lane (
                .clk      (clk),
                .en       (en),
                .adj      (adj[k]),
                .dmag     (dmag),
                .dflag    (dflag),
                .div_elem (div_elem[k]),
                .adj_elem (adj_elem[k]),
                .flags    (flags[k])
            );
        end
    endgenerate

    mi3_merge #(
        .W (W)
    ) u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .mode      (mode_reg),
        .div_elem  (div_elem),
        .adj_elem  (adj_elem),
        .flags     (flags),
        .space     (en),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_elem  (out_elem),
        .out_flag  (out_flag)
    );

    assign out_e0   = out_elem[0];
    assign out_e1   = out_elem[1];
    assign out_e2   = out_elem[2];
    assign out_e3   = out_elem[3];
    assign out_e4   = out_elem[4];
    assign out_e5   = out_elem[5];
    assign out_e6   = out_elem[6];
    assign out_e7   = out_elem[7];
    assign out_e8   = out_elem[8];
    assign singular = out_flag.singular;
    assign overflow = out_flag.overflow;

`ifndef SYNTHESIS
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("input stalled with no result waiting");

    a_singular_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && singular) |-> (!overflow && out_e0 == '0 && out_e1 == '0
            && out_e2 == '0 && out_e3 == '0 && out_e4 == '0 && out_e5 == '0
            && out_e6 == '0 && out_e7 == '0 && out_e8 == '0))
        else $error("singular result carries nonzero data");

    a_adjugate_not_singular: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !mode_reg) |-> !singular)
        else $error("singular flag raised in adjugate mode");
`endif

endmodule

`default_nettype wire

[bench/matrix_inverse_3x3_core_test.sv]
`default_nettype none

module matrix_inverse_3x3_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import mi3_pkg::*;

    localparam int DW = 32;
    localparam int FB = 16;
    localparam int DRAIN_CYCLES = 80;
    localparam int CYCLE_LIMIT = 400000;

    typedef logic signed [255:0] wide_t;
    typedef logic signed [DW-1:0] elem_t;
    typedef elem_t matrix_t [9];

    typedef struct {
        elem_t e [9];
        logic  singular;
        logic  overflow;
    } inverse_t;

    localparam wide_t ELEM_MAX = wide_t'(64'sh7FFF_FFFF);
    localparam wide_t ELEM_MIN = -wide_t'(64'sh8000_0000);
    localparam elem_t Q_ONE = 32'sh0001_0000;
    localparam elem_t E_MAX = 32'sh7FFF_FFFF;
    localparam elem_t E_MIN = 32'sh8000_0000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    elem_t in_e [9] = '{default: '0};
    logic out_valid;
    logic out_ready = 1'b0;
    elem_t out_e [9];
    logic singular;
    logic overflow;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic divide_by_determinant = 1'b1;

    bit mode_divide = 1'b1;
    inverse_t inverse_q [$];
    int errors = 0;
    int cycles = 0;
    int burst_left = 0;
    int hold_request = 0;
    int hold_left = 0;
    int stall_pct = 0;

    always #5 clk = ~clk;

    matrix_inverse_3x3_core #(.DATA_WIDTH(DW), .FRAC_BITS(FB)) u_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .in_e0(in_e[0]), .in_e1(in_e[1]), .in_e2(in_e[2]),
        .in_e3(in_e[3]), .in_e4(in_e[4]), .in_e5(in_e[5]),
        .in_e6(in_e[6]), .in_e7(in_e[7]), .in_e8(in_e[8]),
        .out_valid(out_valid), .out_ready(out_ready),
        .out_e0(out_e[0]), .out_e1(out_e[1]), .out_e2(out_e[2]),
        .out_e3(out_e[3]), .out_e4(out_e[4]), .out_e5(out_e[5]),
        .out_e6(out_e[6]), .out_e7(out_e[7]), .out_e8(out_e[8]),
        .singular(singular), .overflow(overflow),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .divide_by_determinant(divide_by_determinant)
    );

    function automatic elem_t saturate(input wide_t v, inout logic ovf);
        if (v > ELEM_MAX) begin
            ovf = 1'b1;
            return E_MAX;
        end
        if (v < ELEM_MIN) begin
            ovf = 1'b1;
            return E_MIN;
        end
        return elem_t'(v);
    endfunction

    function automatic inverse_t invert_matrix(input matrix_t m, input bit divide);
        inverse_t r;
        wide_t w [9];
        wide_t cof [9];
        wide_t det;
        for (int k = 0; k < 9; k++)
            w[k] = m[k];
        for (int k = 0; k < 9; k++)
            cof[k] = w[ADJ_IDX[k][0]] * w[ADJ_IDX[k][1]] - w[ADJ_IDX[k][2]] * w[ADJ_IDX[k][3]];
        det = w[0] * cof[0] + w[3] * cof[1] + w[6] * cof[2];
        r.singular = 1'b0;
        r.overflow = 1'b0;
        if (!divide) begin
            for (int k = 0; k < 9; k++)
                r.e[k] = saturate(cof[k] >>> FB, r.overflow);
        end
        else if (det == 0) begin
            r.singular = 1'b1;
            for (int k = 0; k < 9; k++)
                r.e[k] = '0;
        end
        else begin
            for (int k = 0; k < 9; k++)
                r.e[k] = saturate((cof[k] <<< (2 * FB)) / det, r.overflow);
        end
        return r;
    endfunction

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // receiver: long hold-off on request, otherwise a drifting stall rate
    always @(posedge clk) begin
        if (hold_request != 0) begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (cycles % 256 == 0)
            stall_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 80);
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            out_ready <= 1'b0;
        end
        else begin
            out_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    always @(posedge clk) begin
        inverse_t want;
        if (rst_n && out_valid && out_ready) begin
            if (inverse_q.size() == 0) begin
                $error("result transaction with no expectation pending");
                errors++;
            end
            else begin
                want = inverse_q.pop_front();
                for (int k = 0; k < 9; k++)
                    if (out_e[k] !== want.e[k]) begin
                        $error("out_e%0d expected %h got %h", k, want.e[k], out_e[k]);
                        errors++;
                    end
                if (singular !== want.singular) begin
                    $error("singular expected %b got %b", want.singular, singular);
                    errors++;
                end
                if (overflow !== want.overflow) begin
                    $error("overflow expected %b got %b", want.overflow, overflow);
                    errors++;
                end
            end
        end
    end

    task automatic send_matrix(input matrix_t m);
        in_valid <= 1'b1;
        for (int k = 0; k < 9; k++)
            in_e[k] <= m[k];
        do
            @(posedge clk);
        while (!(in_valid && in_ready));
        inverse_q.push_back(invert_matrix(m, mode_divide));
    endtask

    task automatic idle_input(input int n);
        in_valid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    task automatic paced_send(input matrix_t m);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if ($urandom_range(0, 3) != 0)
                idle_input($urandom_range(1, 10));
        end
        burst_left--;
        send_matrix(m);
    endtask

    task automatic wait_results_done();
        in_valid <= 1'b0;
        @(posedge clk);
        while (inverse_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_mode(input bit divide);
        wait_results_done();
        cfg_valid <= 1'b1;
        divide_by_determinant <= divide;
        do
            @(posedge clk);
        while (!(cfg_valid && cfg_ready));
        mode_divide = divide;
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic elem_t small_elem();
        return elem_t'($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000;
    endfunction

    function automatic elem_t edge_elem();
        case ($urandom_range(0, 6))
            0: return E_MAX;
            1: return E_MIN;
            2: return '0;
            3: return Q_ONE;
            4: return -Q_ONE;
            5: return 32'sd1;
            default: return elem_t'($urandom());
        endcase
    endfunction

    function automatic matrix_t random_matrix();
        matrix_t m;
        int kind;
        kind = $urandom_range(0, 9);
        for (int k = 0; k < 9; k++)
            case (kind)
                0, 1: m[k] = elem_t'($urandom());
                2: m[k] = edge_elem();
                3: m[k] = elem_t'($urandom()) >>> $urandom_range(0, 31);
                default: m[k] = small_elem();
            endcase
        if (kind == 4) begin
            for (int c = 0; c < 3; c++)
                m[6 + c] = m[$urandom_range(0, 1) * 3 + c];
        end
        else if (kind == 5) begin
            for (int k = 0; k < 9; k += 4)
                m[k] = m[k] + (32'sh0010_0000 * ($urandom_range(0, 1) ? 1 : -1));
        end
        else if (kind == 6) begin
            for (int r = 0; r < 3; r++)
                m[3 * r + 2] = m[3 * r] <<< 1;
        end
        return m;
    endfunction

    task automatic test_directed(input bit divide);
        matrix_t m;
        write_mode(divide);
        send_matrix('{Q_ONE, 0, 0, 0, Q_ONE, 0, 0, 0, Q_ONE});
        send_matrix('{default: '0});
        send_matrix('{default: E_MAX});
        send_matrix('{default: E_MIN});
        send_matrix('{E_MAX, E_MIN, 0, E_MIN, E_MAX, 0, 0, 0, E_MAX});
        send_matrix('{E_MIN, 0, 0, 0, E_MIN, 0, 0, 0, E_MIN});
        send_matrix('{32'sh20000, 0, 0, 0, -32'sh20000, 0, 0, 0, 32'sh8000});
        send_matrix('{1, 0, 0, 0, 1, 0, 0, 0, 1});
        send_matrix('{Q_ONE, 2 * Q_ONE, 3 * Q_ONE, 4 * Q_ONE, 5 * Q_ONE, 6 * Q_ONE,
                      7 * Q_ONE, 8 * Q_ONE, 9 * Q_ONE});
        send_matrix('{0, Q_ONE, 0, Q_ONE, 0, 0, 0, 0, Q_ONE});
        send_matrix('{2 * Q_ONE, Q_ONE, 0, Q_ONE, 3 * Q_ONE, Q_ONE, 0, Q_ONE, 4 * Q_ONE});
        send_matrix('{32'sh7FFF0000, 1, 0, 1, 32'sh7FFF0000, 1, 0, 1, 32'sh7FFF0000});
        for (int k = 0; k < 9; k++)
            m[k] = edge_elem();
        send_matrix(m);
    endtask

    task automatic test_backpressure();
        wait_results_done();
        hold_request = 600;
        for (int i = 0; i < 80; i++)
            send_matrix(random_matrix());
        wait_results_done();
    endtask

    task automatic test_random(input bit divide, input int count);
        write_mode(divide);
        for (int i = 0; i < count; i++)
            paced_send(random_matrix());
    endtask

    initial begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed(1'b1);
        test_directed(1'b0);
        test_random(1'b1, 450);
        test_backpressure();
        test_random(1'b0, 400);
        test_random(1'b1, 470);
        wait_results_done();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

`default_nettype wire

[files.f]
design/mi3_pkg.sv
design/mi3_front.sv
design/mi3_lane.sv
design/mi3_merge.sv
design/matrix_inverse_3x3_core.sv
bench/matrix_inverse_3x3_core_test.sv
